// File: rtl/ffs_pkg.sv
package ffs_pkg;

  // Item actions
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_SEARCH = 2'd2
  } action_t;

  // Fit strategies; code 3 is not a strategy and never fits
  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2
  } strat_t;

  localparam int unsigned FIELD_W = 16;

  // Register byte address of the memory span
  localparam logic [0:0] REG_MEM_SPAN = 1'b0;
  localparam logic [FIELD_W-1:0] MEM_SPAN_RESET = 16'hFFFF;

  // Search request held for the whole pass through the chain
  typedef struct packed {
    logic [FIELD_W-1:0] req;
    logic [1:0]         strat;
  } search_ctl_t;

endpackage

// File: rtl/ffs_cell.sv
module ffs_cell #(
  parameter int IDX       = 0,
  parameter int ADDR_BITS = 16,
  parameter int CNT_W     = 5,
  parameter int SW        = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ffs_pkg::search_ctl_t ctl,
  input  logic [CNT_W-1:0]     count,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_start,
  input  logic [ADDR_BITS-1:0] wr_length,
  input  logic                 adv,
  input  logic                 run_in,
  input  logic                 hit_in,
  input  logic [ADDR_BITS-1:0] pick_in,
  input  logic [SW-1:0]        slack_in,
  output logic                 run_out,
  output logic                 hit_out,
  output logic [ADDR_BITS-1:0] pick_out,
  output logic [SW-1:0]        slack_out
);
  import ffs_pkg::*;

  logic [ADDR_BITS-1:0] start;
  logic [ADDR_BITS-1:0] length;
  logic                 occ;
  logic                 fits;
  logic                 take;
  logic [SW-1:0]        slack;

  // Store the region when the fill count points at this cell
  always_ff @(posedge clk) begin
    if (wr_en && count == CNT_W'(IDX)) begin
      start  <= wr_start;
      length <= wr_length;
    end
  end

  // Compare this region against the passing candidate
  always_comb begin
    occ   = CNT_W'(IDX) < count;
    fits  = run_in && occ && (ctl.req != '0) && (SW'(length) >= SW'(ctl.req));
    slack = SW'(length) - SW'(ctl.req);
    unique case (ctl.strat)
      STRAT_FIRST: take = fits && !hit_in;
      STRAT_BEST:  take = fits && (slack < slack_in);
      STRAT_WORST: take = fits && (!hit_in || slack > slack_in);
      default:     take = 1'b0;
    endcase
  end

  // Hand the updated candidate to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      run_out <= 1'b0;
    end else if (adv) begin
      run_out <= run_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_out   <= hit_in | take;
      pick_out  <= take ? start : pick_in;
      slack_out <= take ? slack : slack_in;
    end
  end

endmodule

// File: rtl/free_block_fit_search_core.sv
// Channel  | Handshake            | Word
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | action, region_start, region_length,
//          |                      | request_size, strategy
// out      | out_valid / out_stall| found, chosen_start
// cfg      | APB psel/penable     | memory span at byte address 0
//
// A search walks the row of ENTRIES cells, one cell per cycle unless the chain is
// frozen, from the launch register through each cell to the output register; the
// next word waits for its result, so the chain length sets the search time.
// in_stall stays high while a search is in the chain. A stalled result leaves the
// input open; the chain freezes only when the next search reaches its end.
// Synchronous reset empties the table and restores the memory span to 65535.
module free_block_fit_search_core #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] region_start,
  input  logic [15:0] region_length,
  input  logic [15:0] request_size,
  input  logic [1:0]  strategy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [15:0] chosen_start,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffs_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int WW    = (ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int SW    = WW + 1;

  logic [FIELD_W-1:0] mem_span;
  logic [CNT_W-1:0]   count;
  search_ctl_t        ctl;
  logic               launch;
  logic               accept;
  logic               adv;
  logic               busy;
  logic               wr_en;
  logic [ENTRIES-1:0] runs;

  logic                 c_run   [ENTRIES+1];
  logic                 c_hit   [ENTRIES+1];
  logic [ADDR_BITS-1:0] c_pick  [ENTRIES+1];
  logic [SW-1:0]        c_slack [ENTRIES+1];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MEM_SPAN) ? {16'd0, mem_span} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_span <= MEM_SPAN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_MEM_SPAN) begin
      mem_span <= pwdata[FIELD_W-1:0];
    end
  end

  // Input handshake: one search in the chain at a time
  always_comb begin
    busy = launch;
    for (int i = 0; i < ENTRIES; i++) begin
      runs[i] = c_run[i+1];
      busy    = busy | c_run[i+1];
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && action == ACT_APPEND && count < CNT_W'(ENTRIES);
  assign adv      = !(c_run[ENTRIES] && out_valid && out_stall);

  // Fill count of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && action == ACT_CLEAR) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end
  end

  // Latch the search request and launch a candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else if (accept && action == ACT_SEARCH) begin
      launch <= 1'b1;
    end else if (adv) begin
      launch <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == ACT_SEARCH) begin
      ctl.req   <= request_size;
      ctl.strat <= strategy;
    end
  end

  // Seed candidate: best fit starts from the slack limit
  assign c_run[0]   = launch;
  assign c_hit[0]   = 1'b0;
  assign c_pick[0]  = '0;
  assign c_slack[0] = (ctl.strat == STRAT_BEST) ? (SW'(mem_span) + SW'(1)) : '0;

  // Row of cells, one region each
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ffs_cell #(
      .IDX       (g),
      .ADDR_BITS (ADDR_BITS),
      .CNT_W     (CNT_W),
      .SW        (SW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (count),
      .wr_en     (wr_en),
      .wr_start  (ADDR_BITS'(region_start)),
      .wr_length (ADDR_BITS'(region_length)),
      .adv       (adv),
      .run_in    (c_run[g]),
      .hit_in    (c_hit[g]),
      .pick_in   (c_pick[g]),
      .slack_in  (c_slack[g]),
      .run_out   (c_run[g+1]),
      .hit_out   (c_hit[g+1]),
      .pick_out  (c_pick[g+1]),
      .slack_out (c_slack[g+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_run[ENTRIES] && adv) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_run[ENTRIES] && adv) begin
      found        <= c_hit[ENTRIES];
      chosen_start <= c_hit[ENTRIES] ? FIELD_W'(c_pick[ENTRIES]) : '0;
    end
  end

  // At most one candidate travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({launch, runs}))
    else $error("more than one search candidate in the chain");

  // The fill count never passes the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table depth");

  // A new result comes only from the end of the chain
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(c_run[ENTRIES]))
    else $error("result appeared without a finished search");

  // A frozen chain keeps its last candidate in place
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (c_run[ENTRIES] && !adv) |=> c_run[ENTRIES])
    else $error("finished search lost while output stalled");

endmodule
